// ===== design/tsjs_pkg.sv =====
package tsjs_pkg;

    // Queue geometry and derived widths.
    localparam int QUEUE_DEPTH = 16;
    localparam int QW          = $clog2(QUEUE_DEPTH);
    localparam int CW          = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes.
    localparam logic [2:0] REG_FIFO_MODE   = 3'd0;
    localparam logic [2:0] REG_QUEUE_CAP   = 3'd1;
    localparam logic [2:0] REG_TIME_SLICE  = 3'd2;
    localparam logic [2:0] REG_JOB_TIMEOUT = 3'd3;
    localparam logic [2:0] REG_MAX_SERVICE = 3'd4;
    localparam logic [2:0] REG_DEF_SERVICE = 3'd5;

    // Command codes of an input transaction.
    localparam logic CMD_ARRIVAL = 1'b0;
    localparam logic CMD_TICK    = 1'b1;

    // Result kinds.
    typedef enum logic [2:0] {
        K_DONE    = 3'd0,
        K_FULL    = 3'd1,
        K_TIMEOUT = 3'd2,
        K_SLA     = 3'd3,
        K_STATUS  = 3'd4
    } t_kind;

    typedef struct packed {
        logic        cmd;
        logic [15:0] job_id;
        logic [15:0] service_ticks;
        logic [31:0] start_stamp;
        logic        real_time;
        logic [31:0] sla_deadline;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] out_job_id;
        logic [4:0]  load;
        logic        queue_full;
        logic        server_busy;
        logic        last;
    } t_out_item;

    // One queued job.
    typedef struct packed {
        logic [15:0] id;
        logic [15:0] remaining;
        logic [31:0] start;
        logic        real_time;
        logic [31:0] deadline;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef enum logic [3:0] {
        S_IDLE, S_ARR, S_TICK, S_RUNCHK, S_PRD, S_PEV, S_PEMIT, S_PDONE,
        S_REMIT, S_TKRD, S_TKLD, S_STATUS
    } t_state;

    // Expiry check: timeout first, then the real-time deadline.
    function automatic t_kind f_expiry(input logic [31:0] now, input logic [31:0] timeout,
                                       input logic [31:0] start, input logic rt,
                                       input logic [31:0] dl);
        t_kind k;
        k = K_DONE;
        if (timeout != 32'd0 && now >= start && (now - start) > timeout) begin
            k = K_TIMEOUT;
        end else if (rt && now > dl) begin
            k = K_SLA;
        end
        return k;
    endfunction

    // Wrap a ring position back into the queue.
    function automatic logic [QW-1:0] f_wrap(input logic [CW:0] s);
        logic [CW:0] t;
        t = (s >= (CW+1)'(QUEUE_DEPTH)) ? s - (CW+1)'(QUEUE_DEPTH) : s;
        return t[QW-1:0];
    endfunction

endpackage

// ===== design/tsjs_in_if.sv =====
interface tsjs_in_if;
    import tsjs_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== design/tsjs_out_if.sv =====
interface tsjs_out_if;
    import tsjs_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== design/time_sliced_job_server_top.sv =====
// Channel   Direction  Payload     Meaning
// i_job     in         t_in_item   job arrival or one time tick
// o_res     out        t_out_item  completed or dropped jobs, then one status result
// cfg       in         i_cfg_*     register writes, taken whenever i_cfg_we is high
//
// An arrival, or a tick on an idle server, passes S_ARR or S_TICK and then S_STATUS
// before the next ready. A tick without a scheduling step passes S_TICK, S_RUNCHK and
// S_STATUS. A tick that ends a slice or a job scans the queue through the single RAM read
// port, visiting S_PRD and S_PEV for each kept job and also S_PEMIT for each dropped job.
// The shared expiry unit is used once per visited job.
// Reset is synchronous and active low; the queue RAM is not cleared.
// A stalled result holds the sequencer in its emitting state; no transaction is taken
// until the status result of the previous one has been registered.
module time_sliced_job_server_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tsjs_in_if.sink     i_job,
    tsjs_out_if.source  o_res,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);
    import tsjs_pkg::*;

    // Configuration registers.
    logic        r_fifo_mode;
    logic [4:0]  r_qcap;
    logic [15:0] r_time_slice;
    logic [31:0] r_timeout;
    logic [15:0] r_max_svc;
    logic [15:0] r_def_svc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fifo_mode  <= 1'b1;
            r_qcap       <= 5'd16;
            r_time_slice <= '0;
            r_timeout    <= '0;
            r_max_svc    <= '0;
            r_def_svc    <= 16'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_FIFO_MODE:   r_fifo_mode  <= i_cfg_data[0];
                REG_QUEUE_CAP:   r_qcap       <= i_cfg_data[4:0];
                REG_TIME_SLICE:  r_time_slice <= i_cfg_data[15:0];
                REG_JOB_TIMEOUT: r_timeout    <= i_cfg_data;
                REG_MAX_SERVICE: r_max_svc    <= i_cfg_data[15:0];
                REG_DEF_SERVICE: r_def_svc    <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Sequencer and scheduler state.
    t_state      r_state, n_state;
    logic [31:0] r_now, n_now;
    logic        r_busy, n_busy;
    t_entry      r_run, n_run;
    logic [15:0] r_slice, n_slice;
    logic [QW-1:0] r_head, n_head;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_wr, n_wr;
    logic        r_end, n_end;
    logic        r_push, n_push;
    t_kind       r_run_kind, n_run_kind;
    t_kind       r_drop_kind, n_drop_kind;
    logic [15:0] r_drop_id, n_drop_id;
    logic        r_cmd, n_cmd;
    t_entry      r_job, n_job;
    logic        r_ovalid, n_ovalid;
    t_out_item   r_out, n_out;

    // Queue memory signals.
    logic          ram_we;
    logic [QW-1:0] ram_waddr;
    logic [QW-1:0] ram_raddr;
    t_entry        ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;
    t_entry        q_rd;

    tsjs_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );
    assign q_rd = t_entry'(ram_rdata);

    // Shared expiry unit, fed by the job under examination.
    t_entry exp_job;
    t_kind  exp_kind;
    always_comb begin
        case (r_state)
            S_RUNCHK: exp_job = r_run;
            S_PEV:    exp_job = q_rd;
            default:  exp_job = r_job;
        endcase
    end
    assign exp_kind = f_expiry(r_now, r_timeout, exp_job.start, exp_job.real_time,
                               exp_job.deadline);

    // Service time of an arriving job: default, then clamp.
    logic [15:0] svc_dflt;
    logic [15:0] svc_req;
    logic [15:0] svc;
    assign svc_dflt = (r_def_svc != 16'd0) ? r_def_svc : 16'd1;
    assign svc_req  = (i_job.data.service_ticks != 16'd0) ? i_job.data.service_ticks : svc_dflt;
    assign svc      = (r_max_svc != 16'd0 && svc_req > r_max_svc) ? r_max_svc : svc_req;

    // Effective capacity and the result handshake.
    logic [CW-1:0] cap;
    logic          can_emit;
    assign cap      = (r_qcap > 5'(QUEUE_DEPTH)) ? CW'(QUEUE_DEPTH) : CW'(r_qcap);
    assign can_emit = !r_ovalid || o_res.ready;

    assign i_job.ready = (r_state == S_IDLE);
    assign o_res.valid = r_ovalid;
    assign o_res.data  = r_out;

    // Next state and datapath control.
    always_comb begin
        n_state     = r_state;
        n_now       = r_now;
        n_busy      = r_busy;
        n_run       = r_run;
        n_slice     = r_slice;
        n_head      = r_head;
        n_count     = r_count;
        n_rd        = r_rd;
        n_wr        = r_wr;
        n_end       = r_end;
        n_push      = r_push;
        n_run_kind  = r_run_kind;
        n_drop_kind = r_drop_kind;
        n_drop_id   = r_drop_id;
        n_cmd       = r_cmd;
        n_job       = r_job;
        n_ovalid    = r_ovalid && !o_res.ready;
        n_out       = r_out;
        ram_we      = 1'b0;
        ram_waddr   = f_wrap((CW+1)'(r_head) + (CW+1)'(r_count));
        ram_wdata   = r_job;
        ram_raddr   = f_wrap((CW+1)'(r_head) + (CW+1)'(r_rd));

        case (r_state)
            // Capture a transaction.
            S_IDLE: begin
                if (i_job.valid) begin
                    n_cmd             = i_job.data.cmd;
                    n_job.id          = i_job.data.job_id;
                    n_job.remaining   = svc;
                    n_job.start       = i_job.data.start_stamp;
                    n_job.real_time   = i_job.data.real_time;
                    n_job.deadline    = i_job.data.sla_deadline;
                    n_state           = (i_job.data.cmd == CMD_TICK) ? S_TICK : S_ARR;
                end
            end
            // Arrival: expire, start, drop for full queue, or enqueue.
            S_ARR: begin
                if (exp_kind != K_DONE || (r_busy && r_count >= cap)) begin
                    if (can_emit) begin
                        n_ovalid = 1'b1;
                        n_out    = '{kind: (exp_kind != K_DONE) ? exp_kind : K_FULL,
                                     out_job_id: r_job.id, load: '0, queue_full: 1'b0,
                                     server_busy: 1'b0, last: 1'b0};
                        n_state  = S_STATUS;
                    end
                end else if (!r_busy) begin
                    n_busy  = 1'b1;
                    n_run   = r_job;
                    n_slice = r_time_slice;
                    n_state = S_STATUS;
                end else begin
                    ram_we  = 1'b1;
                    n_count = r_count + 1'b1;
                    n_state = S_STATUS;
                end
            end
            // Tick: advance time and the running job's counters.
            S_TICK: begin
                n_now = r_now + 32'd1;
                if (r_run.remaining != 16'd0) begin
                    n_run.remaining = r_run.remaining - 16'd1;
                end
                if (r_time_slice != 16'd0 && r_slice != 16'd0) begin
                    n_slice = r_slice - 16'd1;
                end
                n_state = r_busy ? S_RUNCHK : S_STATUS;
            end
            // Decide whether a scheduling step is due.
            S_RUNCHK: begin
                n_run_kind = exp_kind;
                n_end      = (r_run.remaining == 16'd0) || (exp_kind != K_DONE);
                n_rd       = '0;
                n_wr       = '0;
                if (r_run.remaining == 16'd0 || exp_kind != K_DONE
                    || (r_time_slice != 16'd0 && r_slice == 16'd0)) begin
                    n_state = S_PRD;
                end else begin
                    n_state = S_STATUS;
                end
            end
            // Purge: read the next queued job.
            S_PRD: begin
                if (r_rd == r_count) begin
                    n_count = r_wr;
                    n_state = S_PDONE;
                end else begin
                    n_state = S_PEV;
                end
            end
            // Purge: keep the job by compacting it, or report it.
            S_PEV: begin
                if (exp_kind != K_DONE) begin
                    n_drop_kind = exp_kind;
                    n_drop_id   = q_rd.id;
                    n_state     = S_PEMIT;
                end else begin
                    ram_we    = 1'b1;
                    ram_waddr = f_wrap((CW+1)'(r_head) + (CW+1)'(r_wr));
                    ram_wdata = q_rd;
                    n_wr      = r_wr + 1'b1;
                    n_rd      = r_rd + 1'b1;
                    n_state   = S_PRD;
                end
            end
            S_PEMIT: begin
                if (can_emit) begin
                    n_ovalid = 1'b1;
                    n_out    = '{kind: r_drop_kind, out_job_id: r_drop_id, load: '0,
                                 queue_full: 1'b0, server_busy: 1'b0, last: 1'b0};
                    n_rd     = r_rd + 1'b1;
                    n_state  = S_PRD;
                end
            end
            // After the purge: end the running job, or at slice end switch jobs or renew the slice.
            S_PDONE: begin
                n_push = 1'b0;
                if (r_end) begin
                    n_state = S_REMIT;
                end else if (r_count != '0) begin
                    n_push  = 1'b1;
                    n_state = S_TKRD;
                end else begin
                    n_slice = r_time_slice;
                    n_state = S_STATUS;
                end
            end
            S_REMIT: begin
                if (can_emit) begin
                    n_ovalid = 1'b1;
                    n_out    = '{kind: r_run_kind, out_job_id: r_run.id, load: '0,
                                 queue_full: 1'b0, server_busy: 1'b0, last: 1'b0};
                    n_busy   = 1'b0;
                    n_state  = (r_count != '0) ? S_TKRD : S_STATUS;
                end
            end
            // Take the next job from the head or the tail.
            S_TKRD: begin
                ram_raddr = r_fifo_mode ? r_head
                                        : f_wrap((CW+1)'(r_head) + (CW+1)'(r_count) - 1'b1);
                n_state   = S_TKLD;
            end
            S_TKLD: begin
                n_run   = q_rd;
                n_busy  = 1'b1;
                n_slice = r_time_slice;
                if (r_fifo_mode) begin
                    n_head = f_wrap((CW+1)'(r_head) + 1'b1);
                end
                if (r_push) begin
                    ram_we    = 1'b1;
                    ram_wdata = r_run;
                    ram_waddr = r_fifo_mode
                              ? f_wrap((CW+1)'(r_head) + (CW+1)'(r_count))
                              : f_wrap((CW+1)'(r_head) + (CW+1)'(r_count) - 1'b1);
                end else begin
                    n_count = r_count - 1'b1;
                end
                n_state = S_STATUS;
            end
            // Status result closes every transaction.
            S_STATUS: begin
                if (can_emit) begin
                    n_ovalid = 1'b1;
                    n_out    = '{kind: K_STATUS, out_job_id: '0,
                                 load: 5'(r_count) + 5'(r_busy),
                                 queue_full: (cap != '0) && (r_count >= cap),
                                 server_busy: r_busy, last: 1'b1};
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_now    <= '0;
            r_busy   <= 1'b0;
            r_run    <= '0;
            r_slice  <= '0;
            r_head   <= '0;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_now    <= n_now;
            r_busy   <= n_busy;
            r_run    <= n_run;
            r_slice  <= n_slice;
            r_head   <= n_head;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
    end

    // Working registers without reset.
    always_ff @(posedge i_clk) begin
        r_rd        <= n_rd;
        r_wr        <= n_wr;
        r_end       <= n_end;
        r_push      <= n_push;
        r_run_kind  <= n_run_kind;
        r_drop_kind <= n_drop_kind;
        r_drop_id   <= n_drop_id;
        r_cmd       <= n_cmd;
        r_job       <= n_job;
        r_out       <= n_out;
    end

    // Checks.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("queue count beyond depth");
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && !r_busy) |-> r_count == '0)
        else $error("jobs waiting on an idle server");
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_job.valid && i_job.ready) |=> !i_job.ready)
        else $error("second transaction taken while busy");
    a_purge_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PRD || r_state == S_PEV) |-> r_wr <= r_rd)
        else $error("purge write ahead of read");
    a_arr_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ARR) |-> r_cmd == CMD_ARRIVAL)
        else $error("arrival path entered on a tick");
endmodule

// ===== design/tsjs_ram.sv =====
module tsjs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
